// ----- rtl/ostb_pkg.sv -----
`timescale 1ns / 1ps

package ostb_pkg;

  localparam int DUR_W     = 32;
  localparam int ELAPSED_W = 32;
  localparam int FACTOR_W  = 20;
  localparam int PROD_W    = DUR_W + FACTOR_W;
  localparam int SLOT_W    = 4;

  localparam logic [FACTOR_W-1:0] MICRO_FACTOR  = 20'd1;
  localparam logic [FACTOR_W-1:0] MILLI_FACTOR  = 20'd1000;
  localparam logic [FACTOR_W-1:0] SECOND_FACTOR = 20'd1000000;

  localparam logic       CMD_START = 1'b0;
  localparam logic       CMD_TICK  = 1'b1;

  localparam logic       EV_START  = 1'b0;
  localparam logic       EV_EXPIRE = 1'b1;

  localparam logic [1:0] TB_MICRO  = 2'd0;
  localparam logic [1:0] TB_MILLI  = 2'd1;
  localparam logic [1:0] TB_SECOND = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_TICK,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ----- rtl/one_shot_timer_bank_unit.sv -----
`timescale 1ns / 1ps

// channel  | ports                                            | handshake
// ---------+--------------------------------------------------+--------------------------
// command  | command_i duration_i time_base_i elapsed_i       | start_i high, busy_o low
// result   | event_kind_o slot_o last_o                       | valid_o, one cycle each
//
// a start does the scaling multiply, then the load of the slot and its result.
// a tick first registers elapsed, then the timer chain rotates once through the single
// decrement head, one slot per cycle, then a flush step drains the held-back expiry.
// reset closes every slot and points the next start at slot 0; no clearing pass.
// results cannot be stalled; busy_o holds off new commands while one is in progress.

module one_shot_timer_bank_unit #(
  parameter int NUM_TIMERS = 10,
  parameter int TIME_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                command_i,
  input  logic [ostb_pkg::DUR_W-1:0]          duration_i,
  input  logic [1:0]                          time_base_i,
  input  logic [ostb_pkg::ELAPSED_W-1:0]      elapsed_i,
  output logic                                valid_o,
  output logic                                event_kind_o,
  output logic [ostb_pkg::SLOT_W-1:0]         slot_o,
  output logic                                last_o
);

  localparam int EW = ostb_pkg::PROD_W + TIME_WIDTH;
  localparam logic [ostb_pkg::SLOT_W-1:0] LAST_SLOT = ostb_pkg::SLOT_W'(NUM_TIMERS - 1);

  ostb_pkg::state_e state_q, state_d;

  logic [ostb_pkg::SLOT_W-1:0]    next_slot_q, next_slot_d;
  logic [ostb_pkg::SLOT_W-1:0]    step_q, step_d;
  logic                           pend_q, pend_d;
  logic [ostb_pkg::SLOT_W-1:0]    pend_slot_q, pend_slot_d;
  logic [ostb_pkg::ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [ostb_pkg::PROD_W-1:0]    prod_q, prod_d;

  logic                           valid_q, valid_d;
  logic                           kind_q, kind_d;
  logic [ostb_pkg::SLOT_W-1:0]    slot_q, slot_d;
  logic                           last_q, last_d;

  logic                           accept;
  logic [ostb_pkg::FACTOR_W-1:0]  factor;
  logic [EW-1:0]                  prod_ext;
  logic [TIME_WIDTH-1:0]          load_time;

  logic [TIME_WIDTH-1:0]          cell_time [NUM_TIMERS];
  logic                           cell_open [NUM_TIMERS];
  logic [TIME_WIDTH-1:0]          head_time;
  logic                           head_open;
  logic                           head_expire;

  assign accept = start_i && (state_q == ostb_pkg::ST_IDLE);
  assign busy_o = (state_q != ostb_pkg::ST_IDLE);

  always_comb begin
    case (time_base_i)
      ostb_pkg::TB_MILLI:  factor = ostb_pkg::MILLI_FACTOR;
      ostb_pkg::TB_SECOND: factor = ostb_pkg::SECOND_FACTOR;
      default:             factor = ostb_pkg::MICRO_FACTOR;
    endcase
  end

  // saturate the scaled duration at the top of the timer range
  assign prod_ext  = EW'(prod_q);
  assign load_time = (|prod_ext[EW-1:TIME_WIDTH]) ? {TIME_WIDTH{1'b1}}
                                                  : prod_ext[TIME_WIDTH-1:0];

  ostb_head #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_head (
    .time_i   (cell_time[0]),
    .open_i   (cell_open[0]),
    .elapsed_i(elapsed_q),
    .time_o   (head_time),
    .open_o   (head_open),
    .expire_o (head_expire)
  );

  // the chain rotates toward cell 0; the head's result re-enters at the far end
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    ostb_pkg::cell_ctl_t   ctl;
    logic [TIME_WIDTH-1:0] chain_time;
    logic                  chain_open;

    assign ctl.shift = (state_q == ostb_pkg::ST_TICK);
    assign ctl.load  = (state_q == ostb_pkg::ST_SCALE) &&
                       (next_slot_q == ostb_pkg::SLOT_W'(i));

    if (i == NUM_TIMERS - 1) begin : g_tail
      assign chain_time = head_time;
      assign chain_open = head_open;
    end else begin : g_mid
      assign chain_time = cell_time[i+1];
      assign chain_open = cell_open[i+1];
    end

    ostb_cell #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .load_time_i (load_time),
      .chain_time_i(chain_time),
      .chain_open_i(chain_open),
      .time_o      (cell_time[i]),
      .open_o      (cell_open[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    next_slot_d = next_slot_q;
    step_d      = step_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    elapsed_d   = elapsed_q;
    prod_d      = prod_q;
    valid_d     = 1'b0;
    kind_d      = kind_q;
    slot_d      = slot_q;
    last_d      = last_q;

    case (state_q)
      ostb_pkg::ST_IDLE: begin
        if (accept) begin
          if (command_i == ostb_pkg::CMD_START) begin
            prod_d  = ostb_pkg::PROD_W'(duration_i) * ostb_pkg::PROD_W'(factor);
            state_d = ostb_pkg::ST_SCALE;
          end else begin
            elapsed_d = elapsed_i;
            step_d    = '0;
            pend_d    = 1'b0;
            state_d   = ostb_pkg::ST_TICK;
          end
        end
      end
      ostb_pkg::ST_SCALE: begin
        valid_d     = 1'b1;
        kind_d      = ostb_pkg::EV_START;
        slot_d      = next_slot_q;
        last_d      = 1'b1;
        next_slot_d = (next_slot_q == LAST_SLOT) ? '0 : next_slot_q + 1'b1;
        state_d     = ostb_pkg::ST_IDLE;
      end
      ostb_pkg::ST_TICK: begin
        // an expiry is held back one find so that the final one can carry last
        if (head_expire) begin
          if (pend_q) begin
            valid_d = 1'b1;
            kind_d  = ostb_pkg::EV_EXPIRE;
            slot_d  = pend_slot_q;
            last_d  = 1'b0;
          end
          pend_d      = 1'b1;
          pend_slot_d = step_q;
        end
        step_d = step_q + 1'b1;
        if (step_q == LAST_SLOT) begin
          state_d = ostb_pkg::ST_FLUSH;
        end
      end
      ostb_pkg::ST_FLUSH: begin
        if (pend_q) begin
          valid_d = 1'b1;
          kind_d  = ostb_pkg::EV_EXPIRE;
          slot_d  = pend_slot_q;
          last_d  = 1'b1;
        end
        pend_d  = 1'b0;
        state_d = ostb_pkg::ST_IDLE;
      end
      default: begin
        state_d = ostb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ostb_pkg::ST_IDLE;
      next_slot_q <= '0;
      step_q      <= '0;
      pend_q      <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_slot_q <= next_slot_d;
      step_q      <= step_d;
      pend_q      <= pend_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    elapsed_q   <= elapsed_d;
    prod_q      <= prod_d;
    kind_q      <= kind_d;
    slot_q      <= slot_d;
    last_q      <= last_d;
  end

  assign valid_o      = valid_q;
  assign event_kind_o = kind_q;
  assign slot_o       = slot_q;
  assign last_o       = last_q;

`ifndef SYNTH
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (slot_o <= LAST_SLOT))
    else $error("result slot beyond the bank");

  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == ostb_pkg::CMD_START) |-> ##2
      (valid_o && event_kind_o == ostb_pkg::EV_START && last_o))
    else $error("start transaction without its result");

  a_tick_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == ostb_pkg::CMD_TICK) |=> !valid_o)
    else $error("tick result before any slot was visited");

  a_tick_to_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ostb_pkg::ST_TICK && step_q == LAST_SLOT) |=>
      (state_q == ostb_pkg::ST_FLUSH))
    else $error("tick rotation did not end after the last slot");

  a_next_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ostb_pkg::ST_SCALE) |-> (next_slot_q <= LAST_SLOT))
    else $error("round-robin pointer beyond the bank");
`endif

endmodule

// ----- rtl/ostb_cell.sv -----
`timescale 1ns / 1ps

module ostb_cell #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ostb_pkg::cell_ctl_t   ctl_i,
  input  logic [TIME_WIDTH-1:0] load_time_i,
  input  logic [TIME_WIDTH-1:0] chain_time_i,
  input  logic                  chain_open_i,
  output logic [TIME_WIDTH-1:0] time_o,
  output logic                  open_o
);

  logic [TIME_WIDTH-1:0] time_q, time_d;
  logic                  open_q, open_d;

  always_comb begin
    time_d = time_q;
    open_d = open_q;
    if (ctl_i.load) begin
      time_d = load_time_i;
      open_d = 1'b1;
    end else if (ctl_i.shift) begin
      time_d = chain_time_i;
      open_d = chain_open_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      open_q <= 1'b0;
    end else begin
      time_q <= time_d;
      open_q <= open_d;
    end
  end

  assign time_o = time_q;
  assign open_o = open_q;

endmodule

// ----- rtl/ostb_head.sv -----
`timescale 1ns / 1ps

module ostb_head #(
  parameter int TIME_WIDTH = 32
) (
  input  logic [TIME_WIDTH-1:0]          time_i,
  input  logic                           open_i,
  input  logic [ostb_pkg::ELAPSED_W-1:0] elapsed_i,
  output logic [TIME_WIDTH-1:0]          time_o,
  output logic                           open_o,
  output logic                           expire_o
);

  localparam int CW = (TIME_WIDTH > ostb_pkg::ELAPSED_W) ? TIME_WIDTH : ostb_pkg::ELAPSED_W;

  logic [CW-1:0] rem_ext;
  logic [CW-1:0] ela_ext;
  logic          runs_out;

  assign rem_ext  = CW'(time_i);
  assign ela_ext  = CW'(elapsed_i);
  assign runs_out = (ela_ext >= rem_ext);

  always_comb begin
    time_o   = time_i;
    open_o   = open_i;
    expire_o = 1'b0;
    if (open_i) begin
      if (runs_out) begin
        time_o   = '0;
        open_o   = 1'b0;
        expire_o = 1'b1;
      end else begin
        // elapsed is below remaining here, so it fits the timer width
        time_o = time_i - TIME_WIDTH'(ela_ext);
      end
    end
  end

endmodule
